@@ hw/rtl/fnh_pkg.sv @@
// Shared types, constants and CRC-32C helpers for the folded-name hash core.
// No dependencies; imported by fnh_cp_hash and folded_name_crc32c_hash_core.
`default_nettype none

package fnh_pkg;

    // Hashing stops after this many code points per name.
    localparam int unsigned MAX_CODEPOINTS = 1024;
    localparam int CNT_W  = $clog2(MAX_CODEPOINTS + 1);

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int HASH_W = 22;
    localparam int CRC_W  = 32;
    localparam int PEND_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

    // UTF-8 lead byte tags
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Case folding ranges
    localparam logic [CP_W-1:0] ASCII_UP_LO  = 21'h41;
    localparam logic [CP_W-1:0] ASCII_UP_HI  = 21'h5A;
    localparam logic [CP_W-1:0] LATIN_UP_LO  = 21'hC0;
    localparam logic [CP_W-1:0] LATIN_UP_HI  = 21'hDE;
    localparam logic [CP_W-1:0] LATIN_TIMES  = 21'hD7;
    localparam logic [CP_W-1:0] FOLD_OFFSET  = 21'h20;
    localparam logic [CP_W-1:0] SPLIT_LO     = 21'hE0;
    localparam logic [CP_W-1:0] SPLIT_HI     = 21'hFF;

    typedef logic [CRC_W-1:0] t_crc;
    typedef logic [CP_W-1:0]  t_cp;
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_crc_cols;

    // Base letter (0 = no split) and combining mark for 0xE0..0xFF.
    localparam logic [7:0] SPLIT_BASE [32] = '{
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h00, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
        8'h00, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h79
    };
    localparam logic [9:0] SPLIT_MARK [32] = '{
        10'h300, 10'h301, 10'h302, 10'h303, 10'h308, 10'h30A, 10'h000, 10'h327,
        10'h300, 10'h301, 10'h302, 10'h308, 10'h300, 10'h301, 10'h302, 10'h308,
        10'h000, 10'h303, 10'h300, 10'h301, 10'h302, 10'h303, 10'h308, 10'h000,
        10'h000, 10'h300, 10'h301, 10'h302, 10'h308, 10'h301, 10'h000, 10'h308
    };

    // Response of 32 reflected CRC shifts to each single input bit.
    function automatic t_crc_cols crc_cols_f();
        t_crc_cols cols;
        t_crc      c;
        for (int i = 0; i < CRC_W; i++) begin
            c = t_crc'(1) << i;
            for (int k = 0; k < CRC_W; k++) begin
                c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_cols_f();

    // One 32-bit word through the CRC: a flat XOR network over the columns.
    function automatic t_crc crc_word_f(t_crc c);
        t_crc r;
        r = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (c[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fnh_cp_hash.sv @@
// Case fold, Latin-1 split and CRC-32C update for one code point.
// Depends on fnh_pkg.
`default_nettype none

module fnh_cp_hash
    import fnh_pkg::*;
(
    input  wire t_crc i_crc,
    input  wire t_cp  i_cp,
    output t_crc      o_crc
);

    t_cp        fold_cp;
    logic [4:0] split_idx;
    logic       do_split;
    t_crc       word_a;
    t_crc       word_b;
    t_crc       crc_a;
    t_crc       crc_b;

    always_comb begin
        fold_cp = i_cp;
        if ((i_cp >= ASCII_UP_LO && i_cp <= ASCII_UP_HI) ||
            (i_cp >= LATIN_UP_LO && i_cp <= LATIN_UP_HI && i_cp != LATIN_TIMES)) begin
            fold_cp = i_cp + FOLD_OFFSET;
        end
    end

    assign split_idx = fold_cp[4:0];
    assign do_split  = (fold_cp >= SPLIT_LO) && (fold_cp <= SPLIT_HI) &&
                       (SPLIT_BASE[split_idx] != 8'h00);

    // Little-endian word of a code point is just its zero-extended value.
    assign word_a = do_split ? t_crc'(SPLIT_BASE[split_idx]) : t_crc'(fold_cp);
    assign word_b = t_crc'(SPLIT_MARK[split_idx]);

    assign crc_a  = crc_word_f(i_crc ^ word_a);
    assign crc_b  = crc_word_f(crc_a ^ word_b);
    assign o_crc  = do_split ? crc_b : crc_a;

endmodule

`default_nettype wire

@@ hw/rtl/folded_name_crc32c_hash_core.sv @@
// The hash is registered: o_valid rises once the last byte has passed from the byte register into the result register.
// Throughput: one name byte per cycle; a last byte waits in the byte register
// only while the previous hash is still unread on the result channel.
// Reset (i_rst_n low, synchronous): CRC, decoder state, counters and both
// valid flags clear; the core is ready for a byte in the next cycle.
// Depends on fnh_pkg and fnh_cp_hash.
`default_nettype none

module folded_name_crc32c_hash_core
    import fnh_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // byte request channel
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [BYTE_W-1:0] i_name_byte,
    input  wire               i_is_last,
    // hash result channel
    output logic              o_valid,
    input  wire               i_ready,
    output logic [HASH_W-1:0] o_name_hash
);

    // Input register: one byte request waiting to be decoded.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // Result register.
    logic              r_out_valid;
    logic [HASH_W-1:0] r_hash;

    // Per-name decode and hash state.
    t_crc              r_crc,     n_crc;
    t_cp               r_partial, n_partial;
    logic [PEND_W-1:0] r_pend,    n_pend;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic              r_ended,   n_ended;

    logic              proc;
    logic              active;
    logic              take;
    t_cp               take_cp;
    t_cp               cont_cp;
    t_crc              cp_crc;
    t_crc              crc_after;

    // The byte register drains unless it holds a last byte and the result
    // register is still occupied by an unread hash.
    assign proc    = r_in_valid && (!r_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc;

    assign o_valid     = r_out_valid;
    assign o_name_hash = r_hash;

    // Bytes after a terminator or past the code point limit are ignored.
    assign active  = !r_ended && (r_cnt < CNT_W'(MAX_CODEPOINTS));
    assign cont_cp = {r_partial[CP_W-7:0], r_byte[5:0]};

    fnh_cp_hash u_cp_hash (
        .i_crc (r_crc),
        .i_cp  (take_cp),
        .o_crc (cp_crc)
    );

    // UTF-8 decoder: continuation bytes are taken unchecked; invalid leads
    // fall through all branches and are dropped.
    always_comb begin
        n_partial = r_partial;
        n_pend    = r_pend;
        n_ended   = r_ended;
        take      = 1'b0;
        take_cp   = '0;
        if (active) begin
            if (r_pend != '0) begin
                n_partial = cont_cp;
                n_pend    = r_pend - PEND_W'(1);
                if (r_pend == PEND_W'(1)) begin
                    take    = 1'b1;
                    take_cp = cont_cp;
                end
            end else if (r_byte == '0) begin
                n_ended = 1'b1;
            end else if (!r_byte[7]) begin
                take    = 1'b1;
                take_cp = t_cp'(r_byte);
            end else if (r_byte[7:5] == LEAD2_TAG) begin
                n_partial = t_cp'(r_byte[4:0]);
                n_pend    = PEND_W'(1);
            end else if (r_byte[7:4] == LEAD3_TAG) begin
                n_partial = t_cp'(r_byte[3:0]);
                n_pend    = PEND_W'(2);
            end else if (r_byte[7:3] == LEAD4_TAG) begin
                n_partial = t_cp'(r_byte[2:0]);
                n_pend    = PEND_W'(3);
            end
        end

        crc_after = take ? cp_crc : r_crc;
        n_crc     = crc_after;
        n_cnt     = take ? r_cnt + CNT_W'(1) : r_cnt;

        // Last byte: hash goes out, state clears for the next name.
        // A sequence still waiting for continuations is dropped here.
        if (r_last) begin
            n_crc     = '0;
            n_partial = '0;
            n_pend    = '0;
            n_cnt     = '0;
            n_ended   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_name_byte;
            r_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= '0;
            r_partial <= '0;
            r_pend    <= '0;
            r_cnt     <= '0;
            r_ended   <= 1'b0;
        end else if (proc) begin
            r_crc     <= n_crc;
            r_partial <= n_partial;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_ended   <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_last) begin
            r_hash <= crc_after[HASH_W-1:0];
        end
    end

endmodule

`default_nettype wire
